// File: src/c2u_pkg.sv
// ----------------------------------------------------------------------------
// c2u_pkg
// Shared types, constants and the upper control range code point table for
// the Windows-1252 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package c2u_pkg;

    localparam int RUN_MAX     = 3;
    localparam int RUN_LEN_W   = 2;
    localparam int RUN_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    localparam logic [7:0]  ASCII_LIMIT   = 8'h80;
    localparam logic [7:0]  C1_LIMIT      = 8'hA0;
    localparam logic [7:0]  LEAD2_MARK    = 8'hC0;
    localparam logic [7:0]  LEAD3_MARK    = 8'hE0;
    localparam logic [7:0]  CONT_MARK     = 8'h80;
    localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

    // One encoded character: up to three bytes, first byte in seq[0].
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] seq;
        logic [RUN_LEN_W-1:0]    len;
    } run_t;

    // Code points for bytes 0x80..0x9F; zero marks an unassigned position.
    function automatic logic [15:0] c1_code_point(input logic [4:0] idx);
        logic [15:0] cp;
        case (idx)
            5'd0:    cp = 16'h20AC;
            5'd2:    cp = 16'h201A;
            5'd3:    cp = 16'h0192;
            5'd4:    cp = 16'h201E;
            5'd5:    cp = 16'h2026;
            5'd6:    cp = 16'h2020;
            5'd7:    cp = 16'h2021;
            5'd8:    cp = 16'h02C6;
            5'd9:    cp = 16'h2030;
            5'd10:   cp = 16'h0160;
            5'd11:   cp = 16'h2039;
            5'd12:   cp = 16'h0152;
            5'd14:   cp = 16'h017D;
            5'd17:   cp = 16'h2018;
            5'd18:   cp = 16'h2019;
            5'd19:   cp = 16'h201C;
            5'd20:   cp = 16'h201D;
            5'd21:   cp = 16'h2022;
            5'd22:   cp = 16'h2013;
            5'd23:   cp = 16'h2014;
            5'd24:   cp = 16'h02DC;
            5'd25:   cp = 16'h2122;
            5'd26:   cp = 16'h0161;
            5'd27:   cp = 16'h203A;
            5'd28:   cp = 16'h0153;
            5'd30:   cp = 16'h017E;
            5'd31:   cp = 16'h0178;
            default: cp = 16'h0000;
        endcase
        return cp;
    endfunction

endpackage

// File: src/c2u_front.sv
// ----------------------------------------------------------------------------
// c2u_front
// Accepts input bytes, maps them to code points and encodes each assigned one
// as a UTF-8 run that is pushed into the run queue.
// ----------------------------------------------------------------------------
module c2u_front
    import c2u_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       q_full,
    output logic       push,
    output run_t       push_run
);

    logic [15:0] cp;
    logic        accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        if (in_byte < C1_LIMIT)
        begin
            cp = c1_code_point(in_byte[4:0]);
        end
        else
        begin
            cp = {8'h00, in_byte};
        end
    end

    always_comb
    begin
        push_run.seq = '0;
        push_run.len = RUN_LEN_W'(0);
        if (in_byte < ASCII_LIMIT)
        begin
            push_run.seq[0] = in_byte;
            push_run.len    = RUN_LEN_W'(1);
        end
        else if (cp == 16'h0000)
        begin
            // Unassigned position: nothing is emitted.
            push_run.len = RUN_LEN_W'(0);
        end
        else if (cp < TWO_BYTE_LIMIT)
        begin
            push_run.seq[0] = LEAD2_MARK | {3'b000, cp[10:6]};
            push_run.seq[1] = CONT_MARK | {2'b00, cp[5:0]};
            push_run.len    = RUN_LEN_W'(2);
        end
        else
        begin
            push_run.seq[0] = LEAD3_MARK | {4'h0, cp[15:12]};
            push_run.seq[1] = CONT_MARK | {2'b00, cp[11:6]};
            push_run.seq[2] = CONT_MARK | {2'b00, cp[5:0]};
            push_run.len    = RUN_LEN_W'(3);
        end
    end

    assign push = accept && (push_run.len != RUN_LEN_W'(0));

endmodule

// File: src/c2u_queue.sv
// ----------------------------------------------------------------------------
// c2u_queue
// Short queue of encoded runs between the front and back parts.
// ----------------------------------------------------------------------------
module c2u_queue
    import c2u_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  run_t push_run,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output run_t head_run
);

    run_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;

    assign full       = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != QUEUE_CW'(0));
    assign head_run   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QUEUE_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QUEUE_AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_run;
        end
    end

endmodule

// File: src/c2u_back.sv
// ----------------------------------------------------------------------------
// c2u_back
// Walks the run at the head of the queue one byte per cycle while out_stall is low
// into the output register, marking the final byte of each run.
// ----------------------------------------------------------------------------
module c2u_back
    import c2u_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  run_t       head_run,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic [RUN_IDX_W-1:0] idx_reg;
    logic [RUN_IDX_W-1:0] idx_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic [7:0]           byte_reg;
    logic [7:0]           byte_next;
    logic                 last_reg;
    logic                 last_next;
    logic                 load;
    logic                 at_end;

    // The output register takes a new byte whenever it is empty or its
    // current byte leaves in this cycle.
    assign load   = !valid_reg || !out_stall;
    assign at_end = (idx_reg == (head_run.len - RUN_LEN_W'(1)));
    assign pop    = load && head_valid && at_end;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = head_valid;
            if (head_valid)
            begin
                byte_next = head_run.seq[idx_reg];
                last_next = at_end;
                idx_next  = at_end ? RUN_IDX_W'(0) : idx_reg + RUN_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = last_reg;

endmodule

// File: src/cp1252_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// cp1252_to_utf8_transcoder
// Converts a stream of Windows-1252 bytes into a stream of UTF-8 bytes.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+--------------------------------
//  input   | in_valid / in_stall  | in_byte
//  output  | out_valid / out_stall| out_byte, last_of_run
//
// One input byte is taken per cycle while the four-entry run queue has room.
// The output side emits one byte per cycle while out_stall is low; a character
// yields one to three bytes; the serializer at the queue head sets the rate.
// Unassigned bytes are taken and dropped without output.
// Reset clears the queue and the output register; no item is lost on a stall.
//
module cp1252_to_utf8_transcoder
    import c2u_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic push;
    run_t push_run;
    logic pop;
    logic q_full;
    logic head_valid;
    run_t head_run;

    c2u_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .q_full   (q_full),
        .push     (push),
        .push_run (push_run)
    );

    c2u_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_run   (push_run),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_run   (head_run)
    );

    c2u_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_run    (head_run),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

// File: src/c2u_checker.sv
// ----------------------------------------------------------------------------
// c2u_checker
// Port-level checks on the transcoder output stream.
// ----------------------------------------------------------------------------
module c2u_checker
    import c2u_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       last_of_run
);

    // A stalled output byte holds until it is transferred.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_of_run))
        else $error("output byte changed while stalled");

    // Every byte before the last of a run belongs to a multibyte sequence.
    a_not_last_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> out_byte[7])
        else $error("single-byte code not marked last");

    // Lead bytes never close a run.
    a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_byte[7:6] == 2'b11) |-> !last_of_run)
        else $error("lead byte marked last");

    // After a non-final byte is transferred, a continuation byte follows at once.
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid && (out_byte[7:6] == 2'b10))
        else $error("run interrupted or continuation byte malformed");

endmodule

bind cp1252_to_utf8_transcoder c2u_checker u_c2u_checker (.*);

// File: verif/utf8_run_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_run_checker
// Watches both channels of the Windows-1252 to UTF-8 transcoder. It encodes
// every accepted input byte into the UTF-8 bytes it should produce and
// compares each output transfer with the oldest byte still due.
// ----------------------------------------------------------------------------
module utf8_run_checker
    import c2u_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic       last_of_run,
    output int         fail_count,
    output int         bytes_pending
);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } utf8_byte_t;

    utf8_byte_t utf8_bytes_due[$];
    int         mismatch_count = 0;
    int         due_count      = 0;

    assign fail_count    = mismatch_count;
    assign bytes_pending = due_count;

    // Unicode code point of a Windows-1252 byte; zero for unassigned positions.
    function automatic logic [15:0] cp1252_code_point(input logic [7:0] b);
        case (b)
            8'h80: return 16'h20AC;
            8'h82: return 16'h201A;
            8'h83: return 16'h0192;
            8'h84: return 16'h201E;
            8'h85: return 16'h2026;
            8'h86: return 16'h2020;
            8'h87: return 16'h2021;
            8'h88: return 16'h02C6;
            8'h89: return 16'h2030;
            8'h8A: return 16'h0160;
            8'h8B: return 16'h2039;
            8'h8C: return 16'h0152;
            8'h8E: return 16'h017D;
            8'h91: return 16'h2018;
            8'h92: return 16'h2019;
            8'h93: return 16'h201C;
            8'h94: return 16'h201D;
            8'h95: return 16'h2022;
            8'h96: return 16'h2013;
            8'h97: return 16'h2014;
            8'h98: return 16'h02DC;
            8'h99: return 16'h2122;
            8'h9A: return 16'h0161;
            8'h9B: return 16'h203A;
            8'h9C: return 16'h0153;
            8'h9E: return 16'h017E;
            8'h9F: return 16'h0178;
            8'h81, 8'h8D, 8'h8F, 8'h90, 8'h9D: return 16'h0000;
            default: return {8'h00, b};
        endcase
    endfunction

    // Appends one expected byte at the tail of the due list.
    task automatic add_due(input logic [7:0] byte_val, input logic is_last);
        utf8_byte_t entry;
        entry.value = byte_val;
        entry.last  = is_last;
        utf8_bytes_due.insert(utf8_bytes_due.size(), entry);
    endtask

    task automatic queue_encoding(input logic [7:0] b);
        logic [15:0] cp;
        cp = cp1252_code_point(b);
        if (b < ASCII_LIMIT)
        begin
            add_due(b, 1'b1);
        end
        else if (cp == 16'h0000)
        begin
            // Unassigned bytes are swallowed without any output.
        end
        else if (cp < TWO_BYTE_LIMIT)
        begin
            add_due(LEAD2_MARK | {3'b000, cp[10:6]}, 1'b0);
            add_due(CONT_MARK | {2'b00, cp[5:0]}, 1'b1);
        end
        else
        begin
            add_due(LEAD3_MARK | {4'h0, cp[15:12]}, 1'b0);
            add_due(CONT_MARK | {2'b00, cp[11:6]}, 1'b0);
            add_due(CONT_MARK | {2'b00, cp[5:0]}, 1'b1);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        utf8_byte_t want;
        if (!rst_n)
        begin
            utf8_bytes_due.delete();
        end
        else
        begin
            // The input side is handled first so that a same-cycle pass-through
            // would still find its expectation queued.
            if (in_valid && !in_stall)
                queue_encoding(in_byte);
            if (out_valid && !out_stall)
            begin
                if (utf8_bytes_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected transfer out_byte=%h last_of_run=%b",
                                              out_byte, last_of_run));
                end
                else
                begin
                    want = utf8_bytes_due.pop_front();
                    if (out_byte !== want.value)
                        report_mismatch($sformatf("out_byte %h, expected %h",
                                                  out_byte, want.value));
                    if (last_of_run !== want.last)
                        report_mismatch($sformatf("last_of_run %b, expected %b (out_byte %h)",
                                                  last_of_run, want.last, want.value));
                end
            end
        end
        due_count = utf8_bytes_due.size();
    end

endmodule

// File: verif/tb_cp1252_to_utf8_transcoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cp1252_to_utf8_transcoder
// Drives Windows-1252 bytes into the transcoder with random gaps and output
// backpressure, including a long output hold-off that fills the block. The
// checker beside the block predicts and compares every UTF-8 output byte.
// ----------------------------------------------------------------------------
module tb_cp1252_to_utf8_transcoder;

    localparam int RANDOM_ITEMS   = 404;
    localparam int LONG_HOLD      = 200;
    localparam int HOLD_AT_ITEM   = 150;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       last_of_run;

    int fail_count;
    int bytes_pending;
    int idle_cycles = 0;
    bit hold_output = 1'b0;

    logic [7:0] directed_bytes [16] = '{
        8'h00, 8'h7F, 8'h80, 8'h81, 8'h8D, 8'h8F, 8'h90, 8'h9D,
        8'h83, 8'h8C, 8'h99, 8'h9F, 8'hA0, 8'hC3, 8'hFF, 8'h55
    };

    cp1252_to_utf8_transcoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    utf8_run_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run),
        .fail_count    (fail_count),
        .bytes_pending (bytes_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return 8'($urandom_range(8'h00, 8'h7F));
        else if (r < 65)
            return 8'($urandom_range(8'h80, 8'h9F));
        else if (r < 92)
            return 8'($urandom_range(8'hA0, 8'hFF));
        else
        begin
            case ($urandom_range(0, 4))
                0:       return 8'h81;
                1:       return 8'h8D;
                2:       return 8'h8F;
                3:       return 8'h90;
                default: return 8'h9D;
            endcase
        end
    endfunction

    // Offers one byte, waits for its transfer, then idles for the given gap.
    task automatic send_byte(input logic [7:0] b, input int gap);
        in_byte  <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        do
            @(posedge clk);
        while (bytes_pending != 0);
    endtask

    // Sender and verdict.
    initial
    begin
        int         items_sent;
        int         burst_left;
        int         gap;
        bit         hold_started;
        logic [7:0] b;
        items_sent   = 0;
        burst_left   = 0;
        hold_started = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_byte  = 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i], (i == 15) ? 1 : pick_gap());
        wait_for_drain();

        while (items_sent < RANDOM_ITEMS)
        begin
            b = pick_byte();
            // Hold the output off while bytes keep coming so the block fills up.
            if (items_sent >= HOLD_AT_ITEM && !hold_started)
            begin
                hold_started = 1'b1;
                hold_output  = 1'b1;
                burst_left   = 40;
            end
            if (burst_left > 0)
            begin
                gap = 0;
                burst_left--;
            end
            else
            begin
                gap = pick_gap();
                if ($urandom_range(0, 99) < 3)
                    burst_left = 30;
            end
            send_byte(b, gap);
            items_sent++;
        end
        in_valid <= 1'b0;

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("cp1252_to_utf8_transcoder test passed");
        else
            $display("cp1252_to_utf8_transcoder test failed");
        $finish;
    end

    // Receiver: random stall pattern, plus one long hold-off on request.
    initial
    begin
        int flow;
        int hold;
        bit hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_output && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                flow = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 6)
                                                    : $urandom_range(30, 80);
                out_stall <= 1'b0;
                repeat (flow) @(posedge clk);
                hold = pick_gap();
                if (hold > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                end
            end
        end
    end

    // A cycle with no transfer on either channel counts toward the timeout.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("cp1252_to_utf8_transcoder test failed");
            $finish;
        end
    end

endmodule
